[hdl/spq_pkg.sv]
// Shared codes and control types for the sorted priority queue.
// No dependencies; imported by the sequencer, the entry store and the top level.
`default_nettype none

package spq_pkg;

	// request codes carried in s_tuser
	localparam logic [1:0] REQ_ENQ  = 2'd0;
	localparam logic [1:0] REQ_DEQ  = 2'd1;
	localparam logic [1:0] REQ_PEEK = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	localparam int VALUE_BITS = 32;

	// port enables from the sequencer to the entry store
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

`default_nettype wire

[hdl/sorted_priority_queue_unit.sv]
// Sorted priority queue: up to CAPACITY value/priority pairs, largest priority out first,
// equal priorities in arrival order.
//
// Input channel s_*: one request per transaction; s_tuser carries the request code
// (enqueue, dequeue, peek), s_tdata the value and its priority. Output channel m_*: one
// result per request with front value, status, empty flag and entry count after the
// request. Code 3 is a no-op that still reports the count.
//
// Entries sit in a ring buffer, so dequeue and peek need one store read: the front value
// is registered in ST_FRONT, then passes ST_DONE into the output register. Enqueue walks
// from the rear toward the front, one priority compare and one entry move per cycle
// through the single comparator and store port pair. A full or empty error, or an enqueue
// into an empty store, goes straight from idle to ST_DONE with no store read.
// s_tready is high only while the sequencer is idle; one request is in work at a time.
//
// Reset empties the queue at once (pointers and count cleared, no store sweep).
// A result waits in the output register while m_tready is low; the next request is
// still taken and worked on, and its result is held until the register frees.
`default_nettype none

module sorted_priority_queue_unit import spq_pkg::*; #(
	parameter int CAPACITY  = 16,
	parameter int PRIO_BITS = 8,
	localparam int CW    = $clog2(CAPACITY + 1),
	localparam int IN_W  = ((VALUE_BITS + PRIO_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((VALUE_BITS + 3 + CW + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // new_value, priority_req
	input  wire logic [1:0]       s_tuser,  // req_type
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [OUT_W-1:0] m_tdata   // front_value, status, is_empty, entry_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int EW = PRIO_BITS + VALUE_BITS;

	mem_ctl_t              mem_ctl;
	logic [AW-1:0]         wr_addr;
	logic [EW-1:0]         wr_data;
	logic [AW-1:0]         rd_addr;
	logic [EW-1:0]         rd_data;

	logic                  res_valid;
	logic                  res_ready;
	logic [VALUE_BITS-1:0] res_front;
	logic [1:0]            res_status;
	logic [CW-1:0]         res_count;

	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;

	spq_ctrl #(
		.CAPACITY  (CAPACITY),
		.PRIO_BITS (PRIO_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_req     (s_tuser),
		.in_value   (s_tdata[VALUE_BITS-1:0]),
		.in_prio    (s_tdata[EW-1:VALUE_BITS]),
		.mem_ctl    (mem_ctl),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_front  (res_front),
		.res_status (res_status),
		.res_count  (res_count)
	);

	spq_store #(
		.DEPTH (CAPACITY),
		.EW    (EW)
	) u_store (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// zero-fill up to whole bytes
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= OUT_W'({res_count, (res_count == '0), res_status, res_front});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

[hdl/spq_store.sv]
// Entry store of the sorted priority queue: one write and one registered read per cycle.
// Depends on spq_pkg for the port enable struct.
`default_nettype none

module spq_store import spq_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int EW    = 40
) (
	input  wire logic                     clk,
	input  wire mem_ctl_t                 ctl,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [EW-1:0]            wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [EW-1:0]            rd_data
);

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[hdl/spq_ctrl.sv]
// Sequencer of the sorted priority queue: circular ring pointers, one priority
// comparator reused for each shift step of an insert. Depends on spq_pkg.
`default_nettype none

module spq_ctrl import spq_pkg::*; #(
	parameter int CAPACITY  = 16,
	parameter int PRIO_BITS = 8,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int EW = PRIO_BITS + VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            in_req,
	input  wire logic [VALUE_BITS-1:0] in_value,
	input  wire logic [PRIO_BITS-1:0]  in_prio,
	output mem_ctl_t                   mem_ctl,
	output logic      [AW-1:0]         wr_addr,
	output logic      [EW-1:0]         wr_data,
	output logic      [AW-1:0]         rd_addr,
	input  wire logic [EW-1:0]         rd_data,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output logic      [VALUE_BITS-1:0] res_front,
	output logic      [1:0]            res_status,
	output logic      [CW-1:0]         res_count
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CMP   = 3'd1;
	localparam logic [2:0] ST_INS   = 3'd2;
	localparam logic [2:0] ST_FRONT = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

	logic [2:0]            state_q, state_d;
	logic [AW-1:0]         head_q, head_d;
	logic [AW-1:0]         tail_q, tail_d;
	logic [CW-1:0]         count_q, count_d;

	logic [1:0]            req_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [PRIO_BITS-1:0]  prio_q;
	logic [AW-1:0]         wr_ptr_q, wr_ptr_d;
	logic [AW-1:0]         rd_ptr_q, rd_ptr_d;
	logic [CW-1:0]         left_q, left_d;
	logic [VALUE_BITS-1:0] front_q, front_d;
	logic [1:0]            status_q, status_d;

	logic                  accept;
	logic [PRIO_BITS-1:0]  rd_prio;

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
		ring_inc = (p == LAST_IDX) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
		ring_dec = (p == '0) ? LAST_IDX : p - AW'(1);
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign rd_prio  = rd_data[EW-1:VALUE_BITS];

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		count_d     = count_q;
		wr_ptr_d    = wr_ptr_q;
		rd_ptr_d    = rd_ptr_q;
		left_d      = left_q;
		front_d     = front_q;
		status_d    = status_q;
		mem_ctl     = '0;
		wr_addr     = wr_ptr_q;
		wr_data     = {prio_q, val_q};
		rd_addr     = rd_ptr_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					front_d  = '0;
					status_d = STAT_OK;
					state_d  = ST_DONE;
					unique case (in_req)
						REQ_ENQ: begin
							if (count_q == FULL_CNT) begin
								status_d = STAT_FULL;
							end else if (count_q == '0) begin
								// nothing to pass over: write at the rear now
								mem_ctl.wr_en = 1'b1;
								wr_addr       = tail_q;
								wr_data       = {in_prio, in_value};
								tail_d        = ring_inc(tail_q);
								count_d       = count_q + CW'(1);
							end else begin
								mem_ctl.rd_en = 1'b1;
								rd_addr       = ring_dec(tail_q);
								rd_ptr_d      = ring_dec(tail_q);
								wr_ptr_d      = tail_q;
								left_d        = count_q;
								state_d       = ST_CMP;
							end
						end
						REQ_DEQ, REQ_PEEK: begin
							if (count_q == '0) begin
								status_d = STAT_EMPTY;
							end else begin
								mem_ctl.rd_en = 1'b1;
								rd_addr       = head_q;
								state_d       = ST_FRONT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_CMP: begin
				if (rd_prio < prio_q) begin
					// move the lower entry one slot toward the rear
					mem_ctl.wr_en = 1'b1;
					wr_addr       = wr_ptr_q;
					wr_data       = rd_data;
					wr_ptr_d      = rd_ptr_q;
					left_d        = left_q - CW'(1);
					if (left_q == CW'(1)) begin
						state_d = ST_INS;
					end else begin
						mem_ctl.rd_en = 1'b1;
						rd_addr       = ring_dec(rd_ptr_q);
						rd_ptr_d      = ring_dec(rd_ptr_q);
					end
				end else begin
					mem_ctl.wr_en = 1'b1;
					wr_addr       = wr_ptr_q;
					tail_d        = ring_inc(tail_q);
					count_d       = count_q + CW'(1);
					state_d       = ST_DONE;
				end
			end
			ST_INS: begin
				mem_ctl.wr_en = 1'b1;
				wr_addr       = wr_ptr_q;
				tail_d        = ring_inc(tail_q);
				count_d       = count_q + CW'(1);
				state_d       = ST_DONE;
			end
			ST_FRONT: begin
				front_d = rd_data[VALUE_BITS-1:0];
				if (req_q == REQ_DEQ) begin
					head_d  = ring_inc(head_q);
					count_d = count_q - CW'(1);
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= in_req;
			val_q  <= in_value;
			prio_q <= in_prio;
		end
		wr_ptr_q <= wr_ptr_d;
		rd_ptr_q <= rd_ptr_d;
		left_q   <= left_d;
		front_q  <= front_d;
		status_q <= status_d;
	end

	assign res_valid  = (state_q == ST_DONE);
	assign res_front  = front_q;
	assign res_status = status_q;
	assign res_count  = count_q;

endmodule

`default_nettype wire

[hdl/spq_checker.sv]
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg for the status codes and field widths.
`default_nettype none

module spq_checker import spq_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int OUT_W    = 40
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [VALUE_BITS-1:0] front;
	logic [1:0]            status;
	logic                  empty;
	logic [CW-1:0]         count;

	assign front  = m_tdata[VALUE_BITS-1:0];
	assign status = m_tdata[VALUE_BITS+1:VALUE_BITS];
	assign empty  = m_tdata[VALUE_BITS+2];
	assign count  = m_tdata[VALUE_BITS+3+CW-1:VALUE_BITS+3];

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> count <= CW'(CAPACITY) && (empty == (count == '0)))
		else $error("entry count or empty flag inconsistent");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == STAT_FULL |-> count == CW'(CAPACITY) && front == '0)
		else $error("full error with room left");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == STAT_EMPTY |-> empty && front == '0)
		else $error("empty error on a non-empty queue");

	// a request is taken only after the previous one has reached the output side
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in work");

endmodule

bind sorted_priority_queue_unit spq_checker #(
	.CAPACITY (CAPACITY),
	.OUT_W    (OUT_W)
) u_spq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

[verif/tb_sorted_priority_queue_unit.sv]
`timescale 1ns / 1ps
// Self-checking bench for sorted_priority_queue_unit: stream requests in, results out.
// Needs spq_pkg and the block's RTL; holds its own sorted-list predictor in a scoreboard.

module tb_sorted_priority_queue_unit;
	import spq_pkg::*;

	localparam int DEPTH = 16;
	localparam logic [1:0] REQ_NOP = 2'd3;
	localparam int RANDOM_ITEMS = 1950;

	// result word, front value in the lowest bits
	typedef struct packed {
		logic [4:0]  count;
		logic        empty;
		logic [1:0]  status;
		logic [31:0] front;
	} queue_reply_t;

	class spq_scoreboard;
		logic [31:0] held_values[$];
		logic [7:0] held_prios[$];
		queue_reply_t replies_due[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
			errors++;
			$display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
		endtask

		// apply one accepted transaction to the sorted list and queue the reply it earns
		task note_request(input logic [1:0] kind, input logic [31:0] value,
				input logic [7:0] prio);
			queue_reply_t reply;
			int pos;
			reply = '0;
			reply.status = STAT_OK;
			case (kind)
				REQ_ENQ: begin
					if (held_values.size() >= DEPTH) begin
						reply.status = STAT_FULL;
					end else begin
						// go past every entry of greater or equal priority
						pos = 0;
						while (pos < held_prios.size() && held_prios[pos] >= prio)
							pos++;
						held_prios.insert(pos, prio);
						held_values.insert(pos, value);
					end
				end
				REQ_DEQ, REQ_PEEK: begin
					if (held_values.size() == 0) begin
						reply.status = STAT_EMPTY;
					end else begin
						reply.front = held_values[0];
						if (kind == REQ_DEQ) begin
							void'(held_values.pop_front());
							void'(held_prios.pop_front());
						end
					end
				end
				default: ;
			endcase
			reply.count = 5'(held_values.size());
			reply.empty = (held_values.size() == 0);
			replies_due.push_back(reply);
		endtask

		task check_result(input queue_reply_t got);
			queue_reply_t want;
			if (replies_due.size() == 0) begin
				report_mismatch("unexpected result", got.front, 32'd0);
				return;
			end
			want = replies_due.pop_front();
			if (got.front !== want.front)
				report_mismatch("front_value", got.front, want.front);
			if (got.status !== want.status)
				report_mismatch("status", 32'(got.status), 32'(want.status));
			if (got.empty !== want.empty)
				report_mismatch("is_empty", 32'(got.empty), 32'(want.empty));
			if (got.count !== want.count)
				report_mismatch("entry_count", 32'(got.count), 32'(want.count));
		endtask

		function int pending();
			return replies_due.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // new_value, priority_req
	logic [1:0]  s_tuser = REQ_ENQ;  // req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;   // front_value, status, is_empty, entry_count

	logic calm = 1'b0;
	spq_scoreboard sb;

	sorted_priority_queue_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (!calm && $urandom_range(0, 99) < 38)
			m_tready <= 1'b0;
		else
			m_tready <= 1'b1;
	end

	// check results before noting the request taken on the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(queue_reply_t'(m_tdata));
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser, s_tdata[31:0], s_tdata[39:32]);
		end
	end

	// called just after the clock rises; returns once the transaction is taken
	task send_request(input logic [1:0] kind, input logic [31:0] value, input logic [7:0] prio);
		while (!calm && $urandom_range(0, 99) < 38) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {prio, value};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// hold off the sender until every reply is back
	task drain_replies();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	initial begin
		int sent;
		int k;
		int phase_len;
		int mode;
		int roll;
		int enq_lim;
		int deq_lim;
		logic narrow;
		logic [1:0] kind;
		logic [7:0] prio;

		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store errors and the unused code
		send_request(REQ_PEEK, 32'hFFFF_FFFF, 8'hFF);
		send_request(REQ_DEQ, 32'hFFFF_FFFF, 8'hFF);
		send_request(REQ_NOP, 32'hFFFF_FFFF, 8'hFF);
		// extremes, and equal priorities that must leave in arrival order
		send_request(REQ_ENQ, 32'h7FFF_FFFF, 8'hFF);
		send_request(REQ_ENQ, 32'h8000_0000, 8'h00);
		send_request(REQ_ENQ, 32'h0000_0000, 8'h00);
		send_request(REQ_ENQ, 32'hFFFF_FFFF, 8'h80);
		send_request(REQ_PEEK, 32'h0, 8'h0);
		repeat (4) send_request(REQ_DEQ, 32'h0, 8'h0);
		send_request(REQ_DEQ, 32'h0, 8'h0);
		// fill up, then refuse one more
		for (k = 0; k < DEPTH; k++)
			send_request(REQ_ENQ, $urandom, 8'($urandom_range(0, 255)));
		send_request(REQ_ENQ, 32'h1234_5678, 8'hFF);
		send_request(REQ_NOP, 32'h0, 8'h0);
		send_request(REQ_PEEK, 32'h0, 8'h0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 2);
			narrow = $urandom_range(0, 1);
			phase_len = $urandom_range(40, 150);
			case (mode)
				0: begin enq_lim = 70; deq_lim = 85; end  // fill toward full
				1: begin enq_lim = 25; deq_lim = 75; end  // drain toward empty
				default: begin enq_lim = 45; deq_lim = 80; end
			endcase
			if (sent == 0 || $urandom_range(0, 3) == 0)
				drain_replies();
			for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				calm = (sent >= 700 && sent < 1000);
				roll = $urandom_range(0, 99);
				if (roll < enq_lim)
					kind = REQ_ENQ;
				else if (roll < deq_lim)
					kind = REQ_DEQ;
				else if (roll < 97)
					kind = REQ_PEEK;
				else
					kind = REQ_NOP;
				// a narrow phase crowds priorities together to exercise ties
				if (narrow) begin
					case ($urandom_range(0, 3))
						0: prio = 8'h00;
						1: prio = 8'hFF;
						default: prio = 8'($urandom_range(100, 103));
					endcase
				end else begin
					prio = 8'($urandom_range(0, 255));
				end
				send_request(kind, $urandom, prio);
				sent++;
			end
		end
		calm = 1'b0;

		drain_replies();
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
